// File: rtl/peq_pkg.sv
// Shared types and constants for the equal-arc path resampler.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none
package peq_pkg;

    localparam int COORD_W     = 32;
    localparam int SPACING_W   = 31;
    localparam int FRAC_W      = 16;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd1000000;
    localparam int DEFAULT_MAX_PER_SEGMENT = 64;

    // sum of squares, square root of it in Q.16, spacing in Q.16
    localparam int SQ_W   = 2 * COORD_W + 1;
    localparam int ROOT_W = COORD_W + 17;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int DIST_W = SPACING_W + FRAC_W;
    localparam int TOT_W  = ((ROOT_W > DIST_W) ? ROOT_W : DIST_W) + 1;
    localparam int NUM_W  = COORD_W + TOT_W + 2;
    localparam int ITER_W = $clog2(TOT_W + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      starts_path;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      last_of_run;
        logic                      capped;
    } out_item_t;

endpackage
`default_nettype wire

// File: rtl/peq_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on peq_pkg.
`default_nettype none
module peq_mul
    import peq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [COORD_W-1:0]        a,
    input  wire logic [TOT_W-1:0]          b,
    output logic                           done,
    output logic [COORD_W+TOT_W-1:0]       prod
);
    localparam int CW = $clog2(COORD_W + 1);

    logic [TOT_W-1:0]   hi_reg, hi_next;
    logic [COORD_W-1:0] lo_reg, lo_next;
    logic [TOT_W-1:0]   b_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic [TOT_W:0]     sum;

    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : '0);
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[TOT_W:1];
            lo_next  = {sum[0], lo_reg[COORD_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(COORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (start)
            b_reg <= b;
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};
endmodule
`default_nettype wire

// File: rtl/peq_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on peq_pkg.
`default_nettype none
module peq_sqrt
    import peq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);
    localparam int CW = $clog2(ROOT_W + 1);
    localparam int RW = ROOT_W + 4;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [RW-1:0]     rem_t, trial;

    always_comb
    begin
        rem_t     = {rem_reg[RW-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (rem_t >= trial)
            begin
                rem_next  = rem_t - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == CW'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// File: rtl/peq_div.sv
// Restoring divider, one quotient bit per cycle, run length set at start.
// Depends on peq_pkg.
`default_nettype none
module peq_div
    import peq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TOT_W-1:0]  rem_init,
    input  wire logic [TOT_W-1:0]  bits,
    input  wire logic [TOT_W-1:0]  den,
    input  wire logic [ITER_W-1:0] iters,
    output logic                   done,
    output logic [TOT_W-1:0]       quot,
    output logic [TOT_W-1:0]       rem
);
    logic [TOT_W-1:0]  rem_reg, rem_next, bits_reg, bits_next, q_reg, q_next, den_reg;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [TOT_W:0]    rem_t, diff;

    always_comb
    begin
        rem_t     = {rem_reg, bits_reg[TOT_W-1]};
        diff      = rem_t - {1'b0, den_reg};
        rem_next  = rem_reg;
        bits_next = bits_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = rem_init;
            bits_next = bits;
            q_next    = '0;
            cnt_next  = iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bits_next = {bits_reg[TOT_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (rem_t >= {1'b0, den_reg})
            begin
                rem_next = diff[TOT_W-1:0];
                q_next   = {q_reg[TOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_t[TOT_W-1:0];
                q_next   = {q_reg[TOT_W-2:0], 1'b0};
            end
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
        if (start)
            den_reg <= den;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// File: rtl/path_equal_arc_resampler_core.sv
// Equal-arc-length polyline resampler: top level with the sequencer.
// Depends on peq_pkg, peq_mul, peq_sqrt, peq_div.
//
// Usage: vertices enter on in_valid/in_ready (in_item), resampled points
// leave on out_valid/out_ready (out_item). cfg_we writes the spacing register
// (coordinate units, 0 acts as 1); write it only while the block is idle.
// One item is worked at a time: in_ready is high only in the idle state.
// A path-start vertex gives its single point in the cycle after acceptance.
// A later vertex runs two squarings on the shift-add multiplier, a square
// root and a divide for the boundary count before the first point or the
// return to idle. Each interpolated point then takes a multiply and a divide
// for x and for y; a point at the segment end takes neither. At most
// MAX_PER_SEGMENT points leave per vertex, the last one with last_of_run.
// The output register holds a point until out_ready; the sequencer waits on
// it meanwhile. Reset clears the open path, the carried length and any
// pending point, and loads the spacing with its default.
`default_nettype none
module path_equal_arc_resampler_core
    import peq_pkg::*;
#(
    parameter int MAX_PER_SEGMENT = DEFAULT_MAX_PER_SEGMENT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_item,
    input  wire logic                 cfg_we,
    input  wire logic [SPACING_W-1:0] cfg_data
);
    localparam int KW = $clog2(MAX_PER_SEGMENT + 1);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_SQX  = 11'b00000000010,
        ST_SQY  = 11'b00000000100,
        ST_ROOT = 11'b00000001000,
        ST_CNT  = 11'b00000010000,
        ST_PICK = 11'b00000100000,
        ST_MULX = 11'b00001000000,
        ST_DIVX = 11'b00010000000,
        ST_MULY = 11'b00100000000,
        ST_DIVY = 11'b01000000000,
        ST_EMIT = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SPACING_W-1:0] spacing_reg;
    logic [COORD_W-1:0]   prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    logic [DIST_W-1:0]    carried_reg, carried_next;
    logic                 have_prev_reg, have_prev_next;
    logic [COORD_W-1:0]   x1_reg, y1_reg, x1_next, y1_next;
    logic [COORD_W-1:0]   mag_x_reg, mag_y_reg, mag_x_next, mag_y_next;
    logic                 neg_x_reg, neg_y_reg, neg_x_next, neg_y_next;
    logic [2*COORD_W-1:0] sqx_reg, sqx_next;
    logic [ROOT_W-1:0]    seg_reg, seg_next;
    logic [TOT_W-1:0]     pos_reg, pos_next;
    logic [KW-1:0]        n_reg, n_next, k_reg, k_next;
    logic                 cap_reg, cap_next;
    logic [COORD_W-1:0]   res_x_reg, res_x_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    // unit hookup
    logic                       mul_start, mul_done;
    logic [COORD_W-1:0]         mul_a;
    logic [TOT_W-1:0]           mul_b;
    logic [COORD_W+TOT_W-1:0]   mul_prod;
    logic                       sqrt_start, sqrt_done;
    logic [RAD_W-1:0]           sqrt_rad;
    logic [ROOT_W-1:0]          sqrt_root;
    logic                       div_start, div_done;
    logic [TOT_W-1:0]           div_rem_init, div_bits, div_den, div_quot, div_rem;
    logic [ITER_W-1:0]          div_iters;

    // combinational helpers
    logic [SPACING_W-1:0] spacing_eff;
    logic [DIST_W-1:0]    d, lc;
    logic [TOT_W-1:0]     total;
    logic [COORD_W:0]     dx, dy;
    logic [SQ_W-1:0]      sq;
    logic [NUM_W-1:0]     num;
    logic [COORD_W-1:0]   q;
    logic                 accept, start_path, last_pt;

    assign spacing_eff = (spacing_reg == '0) ? SPACING_W'(1) : spacing_reg;
    assign d           = {spacing_eff, {FRAC_W{1'b0}}};
    assign lc          = (carried_reg < d) ? carried_reg : d;
    assign total       = TOT_W'(lc) + TOT_W'(sqrt_root);
    assign dx          = {in_item.point_x[COORD_W-1], in_item.point_x}
                         - {prev_x_reg[COORD_W-1], prev_x_reg};
    assign dy          = {in_item.point_y[COORD_W-1], in_item.point_y}
                         - {prev_y_reg[COORD_W-1], prev_y_reg};
    assign sq          = SQ_W'(sqx_reg) + SQ_W'(mul_prod[2*COORD_W-1:0]);
    assign num         = {1'b0, mul_prod, 1'b0} + NUM_W'(seg_reg);
    assign q           = div_quot[COORD_W-1:0];
    assign accept      = in_valid && in_ready;
    assign start_path  = in_item.starts_path || !have_prev_reg;
    assign last_pt     = (k_reg + 1'b1) == n_reg;
    assign in_ready    = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        carried_next   = carried_reg;
        have_prev_next = have_prev_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        mag_x_next     = mag_x_reg;
        mag_y_next     = mag_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        sqx_next       = sqx_reg;
        seg_next       = seg_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        cap_next       = cap_reg;
        res_x_next     = res_x_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mul_start      = 1'b0;
        mul_a          = mag_x_reg;
        mul_b          = pos_reg;
        sqrt_start     = 1'b0;
        sqrt_rad       = {{(RAD_W-SQ_W-32){1'b0}}, sq, 32'd0};
        div_start      = 1'b0;
        div_rem_init   = num[COORD_W+TOT_W:COORD_W+1];
        div_bits       = {num[COORD_W:0], {(TOT_W-COORD_W-1){1'b0}}};
        div_den        = TOT_W'({seg_reg, 1'b0});
        div_iters      = ITER_W'(COORD_W + 1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x1_next = in_item.point_x;
                    y1_next = in_item.point_y;
                    if (start_path)
                    begin
                        carried_next         = '0;
                        have_prev_next       = 1'b1;
                        out_next.out_x       = in_item.point_x;
                        out_next.out_y       = in_item.point_y;
                        out_next.last_of_run = 1'b1;
                        out_next.capped      = 1'b0;
                        out_valid_next       = 1'b1;
                        state_next           = ST_EMIT;
                    end
                    else
                    begin
                        neg_x_next = dx[COORD_W];
                        neg_y_next = dy[COORD_W];
                        mag_x_next = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
                        mag_y_next = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
                        mul_a      = mag_x_next;
                        mul_b      = TOT_W'(mag_x_next);
                        mul_start  = 1'b1;
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX:
            begin
                if (mul_done)
                begin
                    sqx_next   = mul_prod[2*COORD_W-1:0];
                    mul_a      = mag_y_reg;
                    mul_b      = TOT_W'(mag_y_reg);
                    mul_start  = 1'b1;
                    state_next = ST_SQY;
                end
            end
            ST_SQY:
            begin
                if (mul_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    seg_next     = sqrt_root;
                    pos_next     = TOT_W'(d - lc);
                    div_rem_init = '0;
                    div_bits     = total;
                    div_den      = TOT_W'(d);
                    div_iters    = ITER_W'(TOT_W);
                    div_start    = 1'b1;
                    state_next   = ST_CNT;
                end
            end
            ST_CNT:
            begin
                if (div_done)
                begin
                    carried_next = div_rem[DIST_W-1:0];
                    k_next       = '0;
                    if (div_quot > TOT_W'(MAX_PER_SEGMENT))
                    begin
                        cap_next = 1'b1;
                        n_next   = KW'(MAX_PER_SEGMENT);
                    end
                    else
                    begin
                        cap_next = 1'b0;
                        n_next   = div_quot[KW-1:0];
                    end
                    if (div_quot == '0)
                    begin
                        prev_x_next = x1_reg;
                        prev_y_next = y1_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                        state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (pos_reg >= TOT_W'(seg_reg))
                begin
                    // boundary at or past the segment end: emit the vertex
                    out_next.out_x       = x1_reg;
                    out_next.out_y       = y1_reg;
                    out_next.last_of_run = last_pt;
                    out_next.capped      = cap_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_EMIT;
                end
                else
                begin
                    mul_a      = mag_x_reg;
                    mul_start  = 1'b1;
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    res_x_next = neg_x_reg ? prev_x_reg - q : prev_x_reg + q;
                    mul_a      = mag_y_reg;
                    mul_start  = 1'b1;
                    state_next = ST_MULY;
                end
            end
            ST_MULY:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    out_next.out_x       = res_x_reg;
                    out_next.out_y       = neg_y_reg ? prev_y_reg - q : prev_y_reg + q;
                    out_next.last_of_run = last_pt;
                    out_next.capped      = cap_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last_of_run)
                    begin
                        prev_x_next = x1_reg;
                        prev_y_next = y1_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        // advance to the next boundary
                        k_next     = k_reg + 1'b1;
                        pos_next   = pos_reg + TOT_W'(d);
                        state_next = ST_PICK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spacing_reg   <= SPACING_RESET;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            carried_reg   <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            carried_reg   <= carried_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                spacing_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        sqx_reg   <= sqx_next;
        seg_reg   <= seg_next;
        pos_reg   <= pos_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        cap_reg   <= cap_next;
        res_x_reg <= res_x_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    peq_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    peq_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    peq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .bits     (div_bits),
        .den      (div_den),
        .iters    (div_iters),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );
endmodule
`default_nettype wire
